// File: sv/sha1_stream_hasher_defines.svh
// Assertion macros shared by the SHA-1 hasher checker.
`ifndef SHA1_STREAM_HASHER_DEFINES_SVH
`define SHA1_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SHA1_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sha1 checker: same-cycle property failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SHA1_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sha1 checker: next-cycle property failed");

`endif

// File: sv/sha1_pkg.sv
// Shared types and constants for the SHA-1 stream hasher.
package sha1_pkg;

	typedef logic [31:0] word_t;

	// Control from the message sequencer to the compression engine.
	typedef struct packed {
		logic       byte_en;   // shift one byte into the block buffer
		logic [7:0] byte_val;
		logic       start;     // block is full, run the 80 rounds
		logic       clear;     // reload the initial chaining values
	} sha1_ctl_t;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;   // first length byte of a block
	localparam logic [5:0] LAST_POS = 6'd63;   // last byte of a block
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [2:0] LAST_WORD_IDX = 3'd4;

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	// Index 0 is H0.
	localparam word_t [4:0] H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	function automatic word_t round_k(input logic [6:0] t);
		word_t k;
		if (t < 7'd20)
			k = K0;
		else if (t < 7'd40)
			k = K1;
		else if (t < 7'd60)
			k = K2;
		else
			k = K3;
		return k;
	endfunction

	function automatic word_t round_f(input logic [6:0] t, input word_t b, input word_t c,
		input word_t d);
		word_t f;
		if (t < 7'd20)
			f = (b & c) | (~b & d);
		else if (t < 7'd40 || t >= 7'd60)
			f = b ^ c ^ d;
		else
			f = (b & c) | (b & d) | (c & d);
		return f;
	endfunction

endpackage

// File: sv/sha1_stream_hasher.sv
// SHA-1 stream hasher top level: byte intake, padding sequencer and digest output.
//
// Streaming SHA-1. Each input transaction carries op and msg_byte: op = 0 absorbs
// msg_byte into the current message, op = 1 finishes the message. Bytes are packed
// big-endian into a 64-byte block; when a block fills, the compression engine runs
// 80 rounds, one round per clock, using a single shared round adder and a 16-word
// shifting message schedule, then adds the round variables into the chaining words.
// Timing: a byte that does not complete a block leaves in_ready high, so such bytes
// go back to back; a byte that completes a block holds in_ready low through the 80
// rounds, the chaining add and the hand-back to idle. A finish feeds the padding
// (0x80, zeros, 64-bit big-endian bit length) one byte per cycle, pausing while a
// block compresses mid-padding, with one or two more compressions, then presents
// the five digest words as five output transactions, word_index 0 (most
// significant) first, last_word set on index 4. The block accepts no input until
// the fifth word is taken; then the chaining words, byte count and fill are back
// at their reset values and the next byte starts a new message. The bit length
// wraps modulo 2^64.
module sha1_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  msg_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [2:0] {
		S_IDLE,      // taking message transactions
		S_ABS_WAIT,  // block compressing after an absorbed byte
		S_PAD,       // feeding padding and length bytes
		S_PAD_WAIT,  // block compressing mid-padding
		S_FIN_WAIT,  // final block compressing
		S_EMIT       // presenting digest words
	} state_t;

	state_t                 state_q;
	logic [5:0]             fill_q;     // bytes in the block buffer
	logic [63:0]            count_q;    // byte count; bit length during padding
	logic                   first_q;    // next pad byte is 0x80
	logic                   len_q;      // length bytes under way
	logic [2:0]             idx_q;
	logic [31:0]            digest_q;
	logic                   last_q;

	sha1_pkg::sha1_ctl_t    ctl;
	logic                   core_busy;
	sha1_pkg::word_t [4:0]  chain;

	logic       in_fire, out_fire, len_now;
	logic [7:0] pad_byte;
	logic [2:0] nxt_idx;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	assign digest_word = digest_q;
	assign word_index  = idx_q;
	assign last_word   = last_q;

	// Length goes in once fill reaches 56, except right after the 0x80 byte
	// lands at 56 or later (then zeros run into the next block first).
	assign len_now  = !first_q && (len_q || fill_q == sha1_pkg::LEN_POS);
	assign pad_byte = first_q ? sha1_pkg::PAD_BYTE :
		(len_now ? count_q[63:56] : 8'h00);
	assign nxt_idx  = idx_q + 3'd1;

	always_comb begin
		ctl.byte_en  = (in_fire && op == sha1_pkg::OP_ABSORB) || (state_q == S_PAD);
		ctl.byte_val = (state_q == S_PAD) ? pad_byte : msg_byte;
		ctl.start    = ctl.byte_en && (fill_q == sha1_pkg::LAST_POS);
		ctl.clear    = out_fire && last_q;
	end

	sha1_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.busy   (core_busy),
		.chain  (chain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			count_q  <= '0;
			first_q  <= 1'b0;
			len_q    <= 1'b0;
			idx_q    <= '0;
			digest_q <= '0;
			last_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (op == sha1_pkg::OP_FINISH) begin
							count_q <= {count_q[60:0], 3'b000};
							first_q <= 1'b1;
							len_q   <= 1'b0;
							state_q <= S_PAD;
						end else begin
							count_q <= count_q + 64'd1;
							fill_q  <= fill_q + 6'd1;
							if (fill_q == sha1_pkg::LAST_POS)
								state_q <= S_ABS_WAIT;
						end
					end
				end
				S_ABS_WAIT: begin
					if (!core_busy)
						state_q <= S_IDLE;
				end
				S_PAD: begin
					fill_q  <= fill_q + 6'd1;
					first_q <= 1'b0;
					if (len_now) begin
						len_q   <= 1'b1;
						count_q <= {count_q[55:0], 8'h00};
					end
					if (fill_q == sha1_pkg::LAST_POS)
						state_q <= len_now ? S_FIN_WAIT : S_PAD_WAIT;
				end
				S_PAD_WAIT: begin
					if (!core_busy)
						state_q <= S_PAD;
				end
				S_FIN_WAIT: begin
					if (!core_busy) begin
						digest_q <= chain[0];
						idx_q    <= '0;
						last_q   <= 1'b0;
						state_q  <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_fire) begin
						if (last_q) begin
							// Chaining words reload in the engine this same cycle.
							count_q <= '0;
							len_q   <= 1'b0;
							fill_q  <= '0;
							last_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							idx_q    <= nxt_idx;
							digest_q <= chain[nxt_idx];
							last_q   <= (nxt_idx == sha1_pkg::LAST_WORD_IDX);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: sv/sha1_compress.sv
// SHA-1 block buffer, message schedule and one-round-per-cycle compression.
module sha1_compress (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sha1_pkg::sha1_ctl_t      ctl,
	output logic                     busy,
	output sha1_pkg::word_t [4:0]    chain
);

	typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} cstate_t;

	cstate_t                 state_q;
	logic [6:0]              rnd_q;
	sha1_pkg::word_t [4:0]   chain_q;
	sha1_pkg::word_t [4:0]   wv_q;      // a..e
	logic [511:0]            win_q;     // word 0 in the top 32 bits

	sha1_pkg::word_t w_cur, w_x, w_new, t_sum;

	// Window holds W[t..t+15]; the taps are fixed positions.
	assign w_cur = win_q[511:480];
	assign w_x   = win_q[95:64] ^ win_q[255:224] ^ win_q[447:416] ^ w_cur;
	assign w_new = {w_x[30:0], w_x[31]};

	assign t_sum = {wv_q[0][26:0], wv_q[0][31:27]}
		+ sha1_pkg::round_f(rnd_q, wv_q[1], wv_q[2], wv_q[3])
		+ wv_q[4] + sha1_pkg::round_k(rnd_q) + w_cur;

	assign busy  = (state_q != C_IDLE);
	assign chain = chain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			rnd_q   <= '0;
			chain_q <= sha1_pkg::H_INIT;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (ctl.clear)
						chain_q <= sha1_pkg::H_INIT;
					if (ctl.start) begin
						rnd_q   <= '0;
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == sha1_pkg::LAST_ROUND)
						state_q <= C_ADD;
				end
				C_ADD: begin
					for (int j = 0; j < 5; j++)
						chain_q[j] <= chain_q[j] + wv_q[j];
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// Buffer and round variables carry data only.
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && ctl.byte_en)
			win_q <= {win_q[503:0], ctl.byte_val};
		else if (state_q == C_ROUND)
			win_q <= {win_q[479:0], w_new};

		if (state_q == C_IDLE && ctl.start) begin
			wv_q <= chain_q;
		end else if (state_q == C_ROUND) begin
			wv_q[0] <= t_sum;
			wv_q[1] <= wv_q[0];
			wv_q[2] <= {wv_q[1][1:0], wv_q[1][31:2]};
			wv_q[3] <= wv_q[2];
			wv_q[4] <= wv_q[3];
		end
	end

endmodule

// File: sv/sha1_stream_hasher_checker.sv
// Port-level checker for the SHA-1 stream hasher, bound to the top level.
`include "sha1_stream_hasher_defines.svh"

module sha1_stream_hasher_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// Last flag marks exactly the fifth word.
	`SHA1_ASSERT_IMP(a_last_flag, out_valid, last_word == (word_index == 3'd4))
	// No input taken while the digest is being delivered.
	`SHA1_ASSERT_IMP(a_no_in_during_out, out_valid, !in_ready)
	// Words come out in order with no gap between them.
	`SHA1_ASSERT_NXT(a_word_order, out_valid && out_ready && !last_word,
		out_valid && word_index == $past(word_index) + 3'd1)
	// A stalled digest word holds.
	`SHA1_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(digest_word) && $stable(word_index))

endmodule

bind sha1_stream_hasher sha1_stream_hasher_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.digest_word (digest_word),
	.word_index  (word_index),
	.last_word   (last_word)
);
